// ----- rtl/srec_pkg.sv -----
package srec_pkg;

    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 3;
    localparam int ADDR_W  = 32;
    localparam int DATA_W  = 8;
    localparam int CORE_W  = 12;
    localparam int LOCAL_W = 20;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Event codes carried in event_kind.
    localparam logic [KIND_W-1:0] EV_WRITE    = 3'd0;
    localparam logic [KIND_W-1:0] EV_SECTION  = 3'd1;
    localparam logic [KIND_W-1:0] EV_START    = 3'd2;
    localparam logic [KIND_W-1:0] EV_NO_S     = 3'd3;
    localparam logic [KIND_W-1:0] EV_BAD_TYPE = 3'd4;
    localparam logic [KIND_W-1:0] EV_BAD_CNT  = 3'd5;

    // Register indexes on the configuration port.
    localparam logic REG_BROADCAST_MODE    = 1'b0;
    localparam logic REG_BROADCAST_CORE_ID = 1'b1;

    typedef struct packed {
        logic              broadcast_mode;
        logic [CORE_W-1:0] broadcast_core_id;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [ADDR_W-1:0] write_address;
        logic [DATA_W-1:0] write_data;
    } result_t;

endpackage

// ----- rtl/srec_char_if.sv -----
interface srec_char_if;
    logic                          valid;
    logic                          ready;
    logic [srec_pkg::CHAR_W-1:0]   char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

// ----- rtl/srec_evt_if.sv -----
interface srec_evt_if;
    logic                          valid;
    logic                          ready;
    logic [srec_pkg::KIND_W-1:0]   event_kind;
    logic [srec_pkg::ADDR_W-1:0]   write_address;
    logic [srec_pkg::DATA_W-1:0]   write_data;

    modport source (output valid, output event_kind, output write_address,
                    output write_data, input ready);
    modport sink (input valid, input event_kind, input write_address,
                  input write_data, output ready);
endinterface

// ----- rtl/srec_cfg_regs.sv -----
module srec_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [srec_pkg::PADDR_W-1:0]   paddr,
    input  logic [srec_pkg::PDATA_W-1:0]   pwdata,
    output logic [srec_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output srec_pkg::cfg_t                 cfg
);

    logic                          mode_reg;
    logic [srec_pkg::CORE_W-1:0]   core_id_reg;
    logic                          wr_en;
    logic                          reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    // Registers sit on word boundaries; the byte offset within a word is ignored.
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            core_id_reg <= '0;
        end
        else if (wr_en)
        begin
            if (reg_sel == srec_pkg::REG_BROADCAST_MODE)
            begin
                mode_reg <= pwdata[0];
            end
            else
            begin
                core_id_reg <= pwdata[srec_pkg::CORE_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel == srec_pkg::REG_BROADCAST_MODE)
        begin
            prdata[0] = mode_reg;
        end
        else
        begin
            prdata[srec_pkg::CORE_W-1:0] = core_id_reg;
        end
    end

    assign cfg.broadcast_mode    = mode_reg;
    assign cfg.broadcast_core_id = core_id_reg;

endmodule

// ----- rtl/srec_parser.sv -----
module srec_parser
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [srec_pkg::CHAR_W-1:0]   char_in,
    input  srec_pkg::cfg_t                cfg,
    input  logic                          out_space,
    output logic                          step_fire,
    output logic                          step_has_result,
    output srec_pkg::result_t             step_result
);

    typedef enum logic [2:0] {
        PH_WAIT_S,
        PH_TYPE,
        PH_COUNT,
        PH_ADDR,
        PH_DATA,
        PH_SKIP
    } phase_t;

    typedef enum logic [1:0] {
        KIND_S0,
        KIND_S3,
        KIND_S7
    } rec_kind_t;

    localparam logic [srec_pkg::CHAR_W-1:0] CH_LF   = 8'h0A;
    localparam logic [srec_pkg::CHAR_W-1:0] CH_CR   = 8'h0D;
    localparam logic [srec_pkg::CHAR_W-1:0] CH_S    = 8'h53;
    localparam logic [srec_pkg::CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [srec_pkg::CHAR_W-1:0] CH_3    = 8'h33;
    localparam logic [srec_pkg::CHAR_W-1:0] CH_7    = 8'h37;

    localparam logic [7:0] NEED_S0     = 8'd3;
    localparam logic [7:0] NEED_S3_S7  = 8'd5;
    localparam logic [3:0] DIGITS_S0   = 4'd4;
    localparam logic [3:0] DIGITS_S3_7 = 4'd8;

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [srec_pkg::CHAR_W-1:0]   s1_char_reg;

    phase_t                        phase_reg, phase_next;
    rec_kind_t                     kind_reg, kind_next;
    logic [3:0]                    digit_count_reg, digit_count_next;
    logic [7:0]                    bytes_left_reg, bytes_left_next;
    logic [srec_pkg::ADDR_W-1:0]   addr_acc_reg, addr_acc_next;
    logic [3:0]                    high_nibble_reg, high_nibble_next;
    logic [srec_pkg::CORE_W-1:0]   core_off_reg, core_off_next;

    logic                          in_fire;
    logic                          is_eol;
    logic                          hex_ok;
    logic [3:0]                    hex_val;
    logic [7:0]                    count;
    logic [7:0]                    need;
    logic [3:0]                    digits;
    logic [3:0]                    digit_inc;
    logic [srec_pkg::ADDR_W-1:0]   addr_shift;
    logic [srec_pkg::CORE_W-1:0]   s0_id;
    logic [7:0]                    bytes_dec;

    assign step_fire = s1_valid_reg && out_space;
    assign in_ready  = !s1_valid_reg || step_fire;
    assign in_fire   = in_valid && in_ready;
    assign s1_valid_next = in_fire || (s1_valid_reg && !step_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_char_reg <= char_in;
        end
    end

    // Hex digit decode.
    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (s1_char_reg inside {["0":"9"]})
        begin
            hex_val = 4'(s1_char_reg - CH_ZERO);
        end
        else if (s1_char_reg inside {["A":"F"]})
        begin
            hex_val = 4'(s1_char_reg - 8'h37);
        end
        else if (s1_char_reg inside {["a":"f"]})
        begin
            hex_val = 4'(s1_char_reg - 8'h57);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign is_eol     = (s1_char_reg == CH_LF) || (s1_char_reg == CH_CR);
    assign count      = {high_nibble_reg, hex_val};
    assign need       = (kind_reg == KIND_S0) ? NEED_S0 : NEED_S3_S7;
    assign digits     = (kind_reg == KIND_S0) ? DIGITS_S0 : DIGITS_S3_7;
    assign digit_inc  = digit_count_reg + 4'd1;
    assign addr_shift = {addr_acc_reg[srec_pkg::ADDR_W-5:0], hex_val};
    assign s0_id      = cfg.broadcast_mode ? cfg.broadcast_core_id
                                           : addr_shift[srec_pkg::CORE_W-1:0];
    assign bytes_dec  = bytes_left_reg - 8'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        kind_next        = kind_reg;
        digit_count_next = digit_count_reg;
        bytes_left_next  = bytes_left_reg;
        addr_acc_next    = addr_acc_reg;
        high_nibble_next = high_nibble_reg;
        core_off_next    = core_off_reg;
        step_has_result  = 1'b0;
        step_result.event_kind    = srec_pkg::EV_WRITE;
        step_result.write_address = '0;
        step_result.write_data    = '0;

        if (is_eol)
        begin
            phase_next = PH_WAIT_S;
        end
        else
        begin
            case (phase_reg)
                PH_WAIT_S:
                begin
                    if (s1_char_reg == CH_S)
                    begin
                        phase_next = PH_TYPE;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                        step_has_result = 1'b1;
                        step_result.event_kind = srec_pkg::EV_NO_S;
                    end
                end
                PH_TYPE:
                begin
                    phase_next       = PH_COUNT;
                    digit_count_next = 4'd0;
                    if (s1_char_reg == CH_ZERO)
                    begin
                        kind_next = KIND_S0;
                    end
                    else if (s1_char_reg == CH_3)
                    begin
                        kind_next = KIND_S3;
                    end
                    else if (s1_char_reg == CH_7)
                    begin
                        kind_next = KIND_S7;
                    end
                    else
                    begin
                        phase_next       = PH_SKIP;
                        digit_count_next = digit_count_reg;
                        step_has_result  = 1'b1;
                        step_result.event_kind = srec_pkg::EV_BAD_TYPE;
                    end
                end
                PH_COUNT:
                begin
                    if (!hex_ok)
                    begin
                        phase_next = PH_SKIP;
                        step_has_result = 1'b1;
                        step_result.event_kind = srec_pkg::EV_BAD_CNT;
                    end
                    else if (digit_count_reg == 4'd0)
                    begin
                        high_nibble_next = hex_val;
                        digit_count_next = 4'd1;
                    end
                    else if (count < need)
                    begin
                        // A zero count is caught here as well, since need is never zero.
                        phase_next = PH_SKIP;
                        step_has_result = 1'b1;
                        step_result.event_kind = srec_pkg::EV_BAD_CNT;
                    end
                    else
                    begin
                        bytes_left_next  = count - need;
                        addr_acc_next    = '0;
                        digit_count_next = 4'd0;
                        phase_next       = PH_ADDR;
                    end
                end
                PH_ADDR:
                begin
                    if (!hex_ok)
                    begin
                        phase_next = PH_SKIP;
                        step_has_result = 1'b1;
                        step_result.event_kind = srec_pkg::EV_BAD_CNT;
                    end
                    else
                    begin
                        addr_acc_next    = addr_shift;
                        digit_count_next = digit_inc;
                        if (digit_inc == digits)
                        begin
                            digit_count_next = 4'd0;
                            phase_next       = PH_SKIP;
                            case (kind_reg)
                                KIND_S0:
                                begin
                                    core_off_next   = s0_id;
                                    step_has_result = 1'b1;
                                    step_result.event_kind    = srec_pkg::EV_SECTION;
                                    step_result.write_address =
                                        srec_pkg::ADDR_W'(s0_id);
                                end
                                KIND_S7:
                                begin
                                    if (addr_shift != '0)
                                    begin
                                        step_has_result = 1'b1;
                                        step_result.event_kind    = srec_pkg::EV_START;
                                        step_result.write_address = addr_shift;
                                    end
                                end
                                default:
                                begin
                                    if (cfg.broadcast_mode)
                                    begin
                                        addr_acc_next = {cfg.broadcast_core_id,
                                            addr_shift[srec_pkg::LOCAL_W-1:0]};
                                    end
                                    else if (addr_shift[srec_pkg::ADDR_W-1:
                                                        srec_pkg::LOCAL_W] == '0)
                                    begin
                                        addr_acc_next = {core_off_reg,
                                            addr_shift[srec_pkg::LOCAL_W-1:0]};
                                    end
                                    if (bytes_left_reg != 8'd0)
                                    begin
                                        phase_next = PH_DATA;
                                    end
                                end
                            endcase
                        end
                    end
                end
                PH_DATA:
                begin
                    if (!hex_ok)
                    begin
                        phase_next = PH_SKIP;
                        step_has_result = 1'b1;
                        step_result.event_kind = srec_pkg::EV_BAD_CNT;
                    end
                    else if (digit_count_reg == 4'd0)
                    begin
                        high_nibble_next = hex_val;
                        digit_count_next = 4'd1;
                    end
                    else
                    begin
                        digit_count_next = 4'd0;
                        addr_acc_next    = addr_acc_reg + 32'd1;
                        bytes_left_next  = bytes_dec;
                        if (bytes_dec == 8'd0)
                        begin
                            phase_next = PH_SKIP;
                        end
                        step_has_result = 1'b1;
                        step_result.event_kind    = srec_pkg::EV_WRITE;
                        step_result.write_address = addr_acc_reg;
                        step_result.write_data    = count;
                    end
                end
                default:
                begin
                    phase_next = PH_SKIP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_WAIT_S;
            kind_reg        <= KIND_S0;
            digit_count_reg <= '0;
            bytes_left_reg  <= '0;
            addr_acc_reg    <= '0;
            high_nibble_reg <= '0;
            core_off_reg    <= '0;
        end
        else if (step_fire)
        begin
            phase_reg       <= phase_next;
            kind_reg        <= kind_next;
            digit_count_reg <= digit_count_next;
            bytes_left_reg  <= bytes_left_next;
            addr_acc_reg    <= addr_acc_next;
            high_nibble_reg <= high_nibble_next;
            core_off_reg    <= core_off_next;
        end
    end

    a_eol_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && is_eol |=> phase_reg == PH_WAIT_S)
        else $error("line end did not return the parser to waiting for S");

    a_error_skips: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && step_has_result &&
        (step_result.event_kind == srec_pkg::EV_NO_S ||
         step_result.event_kind == srec_pkg::EV_BAD_TYPE ||
         step_result.event_kind == srec_pkg::EV_BAD_CNT) |=> phase_reg == PH_SKIP)
        else $error("error event not followed by line skip");

    a_data_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> bytes_left_reg != 8'd0)
        else $error("data phase entered with no bytes left");

    a_data_digit_pair: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> digit_count_reg <= 4'd1)
        else $error("data digit count out of step");

endmodule

// ----- rtl/srec_out_stage.sv -----
module srec_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_fire,
    input  logic                 step_has_result,
    input  srec_pkg::result_t    step_result,
    output logic                 out_space,
    output logic                 out_valid,
    input  logic                 out_ready,
    output srec_pkg::result_t    out_data
);

    logic                 out_valid_reg;
    logic                 out_valid_next;
    srec_pkg::result_t    out_data_reg;
    logic                 load;

    assign out_space      = !out_valid_reg || out_ready;
    assign load           = step_fire && step_has_result;
    assign out_valid_next = load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/srec_record_loader.sv -----
// A character is registered on acceptance, its result word when the parse step fires.
// One character per cycle while out_space holds; the parse state updates in a single step.
// A stalled result word holds in the output register while one more character waits.
// Reset (rst_n, asynchronous, active low) returns the parser to waiting for S,
// clears the core offset and both configuration registers, and empties both stages.
module srec_record_loader
(
    input  logic                           clk,
    input  logic                           rst_n,
    srec_char_if.sink                      char_chan,
    srec_evt_if.source                     evt_chan,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [srec_pkg::PADDR_W-1:0]   paddr,
    input  logic [srec_pkg::PDATA_W-1:0]   pwdata,
    output logic [srec_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    srec_pkg::cfg_t       cfg;
    logic                 out_space;
    logic                 step_fire;
    logic                 step_has_result;
    srec_pkg::result_t    step_result;
    srec_pkg::result_t    out_data;

    srec_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srec_parser u_parser
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (char_chan.valid),
        .in_ready        (char_chan.ready),
        .char_in         (char_chan.char_in),
        .cfg             (cfg),
        .out_space       (out_space),
        .step_fire       (step_fire),
        .step_has_result (step_has_result),
        .step_result     (step_result)
    );

    srec_out_stage u_out_stage
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .step_fire       (step_fire),
        .step_has_result (step_has_result),
        .step_result     (step_result),
        .out_space       (out_space),
        .out_valid       (evt_chan.valid),
        .out_ready       (evt_chan.ready),
        .out_data        (out_data)
    );

    assign evt_chan.event_kind    = out_data.event_kind;
    assign evt_chan.write_address = out_data.write_address;
    assign evt_chan.write_data    = out_data.write_data;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    import srec_pkg::*;

    localparam logic [CHAR_W-1:0] LF = 8'h0A;
    localparam logic [CHAR_W-1:0] CR = 8'h0D;
    localparam logic [ADDR_W-1:0] LOCAL_LIMIT = 32'h1 << LOCAL_W;
    localparam int SETTLE_CYCLES = 6;
    localparam int QUIET_LIMIT   = 2000;
    localparam int REPORT_CAP    = 40;
    localparam int PHASE_CHARS   = 160;

    typedef enum logic [2:0] {
        LOOK_FOR_S,
        READ_TYPE,
        READ_COUNT,
        READ_ADDR,
        READ_DATA,
        SKIP_LINE
    } parse_phase_e;

    typedef enum logic [1:0] {
        REC_S0,
        REC_S3,
        REC_S7
    } rec_kind_e;

    logic clk = 1'b0;
    logic rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    srec_char_if char_chan ();
    srec_evt_if  evt_chan ();

    srec_record_loader i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_chan (char_chan),
        .evt_chan  (evt_chan),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Copy of the parser state and of the registers, kept in step with accepted characters.
    logic              cfg_mode;
    logic [CORE_W-1:0] cfg_core_id;
    parse_phase_e      st_phase;
    rec_kind_e         st_kind;
    logic [3:0]        st_digits;
    logic [7:0]        st_bytes;
    logic [ADDR_W-1:0] st_acc;
    logic [3:0]        st_nibble;
    logic [CORE_W-1:0] st_core_offset;

    result_t           pending_events[$];
    logic [CHAR_W-1:0] line_buf[$];

    int  fail_count;
    int  chars_sent;
    int  settings_applied;
    int  kind_count[0:7];
    int  quiet_cycles;
    int  sink_stall;
    bit  sender_eager;
    bit  sink_eager;

    function automatic int hex_digit(input logic [CHAR_W-1:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        return -1;
    endfunction

    function automatic void post_event(input logic [KIND_W-1:0] kind,
                                       input logic [ADDR_W-1:0] addr,
                                       input logic [DATA_W-1:0] data);
        result_t ev;
        ev.event_kind    = kind;
        ev.write_address = addr;
        ev.write_data    = data;
        pending_events.push_back(ev);
    endfunction

    function automatic void raise_error(input logic [KIND_W-1:0] kind);
        st_phase = SKIP_LINE;
        post_event(kind, '0, '0);
    endfunction

    function automatic void decode_char(input logic [CHAR_W-1:0] c);
        int                h;
        logic [7:0]        count;
        logic [7:0]        need;
        logic [CORE_W-1:0] id;
        h = hex_digit(c);
        if (c == LF || c == CR)
        begin
            st_phase = LOOK_FOR_S;
            return;
        end
        case (st_phase)
            LOOK_FOR_S:
            begin
                if (c != "S")
                    raise_error(EV_NO_S);
                else
                    st_phase = READ_TYPE;
            end
            READ_TYPE:
            begin
                if (c == "0")
                    st_kind = REC_S0;
                else if (c == "3")
                    st_kind = REC_S3;
                else if (c == "7")
                    st_kind = REC_S7;
                else
                begin
                    raise_error(EV_BAD_TYPE);
                    return;
                end
                st_phase  = READ_COUNT;
                st_digits = '0;
            end
            READ_COUNT:
            begin
                if (h < 0)
                    raise_error(EV_BAD_CNT);
                else if (st_digits == 0)
                begin
                    st_nibble = h[3:0];
                    st_digits = 4'd1;
                end
                else
                begin
                    count = {st_nibble, h[3:0]};
                    need  = (st_kind == REC_S0) ? 8'd3 : 8'd5;
                    if (count == 0 || count < need)
                        raise_error(EV_BAD_CNT);
                    else
                    begin
                        st_bytes  = count - need;
                        st_acc    = '0;
                        st_digits = '0;
                        st_phase  = READ_ADDR;
                    end
                end
            end
            READ_ADDR:
            begin
                if (h < 0)
                    raise_error(EV_BAD_CNT);
                else
                begin
                    st_acc    = {st_acc[ADDR_W-5:0], h[3:0]};
                    st_digits = st_digits + 4'd1;
                    if (st_digits == ((st_kind == REC_S0) ? 4'd4 : 4'd8))
                    begin
                        st_digits = '0;
                        if (st_kind == REC_S0)
                        begin
                            id             = cfg_mode ? cfg_core_id : st_acc[CORE_W-1:0];
                            st_core_offset = id;
                            st_phase       = SKIP_LINE;
                            post_event(EV_SECTION, {20'h0, id}, '0);
                        end
                        else if (st_kind == REC_S7)
                        begin
                            st_phase = SKIP_LINE;
                            if (st_acc != 0)
                                post_event(EV_START, st_acc, '0);
                        end
                        else
                        begin
                            // Broadcast forces the core field; otherwise only local
                            // addresses pick up the offset from the last S0.
                            if (cfg_mode)
                                st_acc = {cfg_core_id, st_acc[LOCAL_W-1:0]};
                            else if (st_acc < LOCAL_LIMIT)
                                st_acc = {st_core_offset, st_acc[LOCAL_W-1:0]};
                            st_phase = (st_bytes == 0) ? SKIP_LINE : READ_DATA;
                        end
                    end
                end
            end
            READ_DATA:
            begin
                if (h < 0)
                    raise_error(EV_BAD_CNT);
                else if (st_digits == 0)
                begin
                    st_nibble = h[3:0];
                    st_digits = 4'd1;
                end
                else
                begin
                    st_digits = '0;
                    post_event(EV_WRITE, st_acc, {st_nibble, h[3:0]});
                    st_acc   = st_acc + 32'd1;
                    st_bytes = st_bytes - 8'd1;
                    if (st_bytes == 0)
                        st_phase = SKIP_LINE;
                end
            end
            default:
            begin
                st_phase = SKIP_LINE;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (got !== want)
        begin
            if (fail_count < REPORT_CAP)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, what, want, got);
            fail_count++;
        end
    endtask

    // Text building.

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic void put_hex(input logic [31:0] value, input int digits);
        logic [7:0] nib;
        for (int i = digits - 1; i >= 0; i--)
        begin
            nib = {4'h0, value[4*i +: 4]};
            if (nib < 10)
                line_buf.push_back(nib + "0");
            else if ($urandom_range(0, 2) == 0)
                line_buf.push_back(nib - 8'd10 + "a");
            else
                line_buf.push_back(nib - 8'd10 + "A");
        end
    endfunction

    function automatic logic [CHAR_W-1:0] pick_non_hex();
        logic [CHAR_W-1:0] c;
        c = CHAR_W'($urandom_range(0, 255));
        while (hex_digit(c) >= 0 || c == LF || c == CR)
            c = CHAR_W'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_type_char();
        case ($urandom_range(0, 2))
            0: return "0";
            1: return "3";
            default: return "7";
        endcase
    endfunction

    function automatic void put_line_end();
        case ($urandom_range(0, 4))
            0: line_buf.push_back(LF);
            1: line_buf.push_back(CR);
            2: put_text("\r\n");
            3: put_text("\n\n");
            default: put_text("\n\r");
        endcase
    endfunction

    function automatic void make_broken_line();
        logic [CHAR_W-1:0] c;
        logic [CHAR_W-1:0] tc;
        int                n;
        case ($urandom_range(0, 7))
            0:
            begin
                c = CHAR_W'($urandom_range(0, 255));
                while (c == "S" || c == LF || c == CR)
                    c = CHAR_W'($urandom_range(0, 255));
                line_buf.push_back(c);
                repeat ($urandom_range(0, 6)) put_hex($urandom(), 2);
            end
            1:
            begin
                c = CHAR_W'($urandom_range(0, 255));
                while (c == "0" || c == "3" || c == "7" || c == LF || c == CR)
                    c = CHAR_W'($urandom_range(0, 255));
                line_buf.push_back("S");
                line_buf.push_back(c);
            end
            2:
            begin
                line_buf.push_back("S");
                line_buf.push_back(pick_type_char());
                put_text("00");
            end
            3:
            begin
                tc = pick_type_char();
                line_buf.push_back("S");
                line_buf.push_back(tc);
                put_hex((tc == "0") ? $urandom_range(1, 2) : $urandom_range(1, 4), 2);
            end
            4:
            begin
                line_buf.push_back("S");
                line_buf.push_back(pick_type_char());
                if ($urandom_range(0, 1) == 1)
                    put_hex($urandom(), 1);
                line_buf.push_back(pick_non_hex());
            end
            5:
            begin
                tc = pick_type_char();
                line_buf.push_back("S");
                line_buf.push_back(tc);
                put_hex(((tc == "0") ? 3 : 5) + $urandom_range(0, 4), 2);
                put_hex($urandom(), $urandom_range(0, (tc == "0") ? 3 : 7));
                line_buf.push_back(pick_non_hex());
            end
            6:
            begin
                // A bad digit part-way through the data; earlier bytes still count.
                n = $urandom_range(2, 6);
                put_text("S3");
                put_hex(n + 5, 2);
                put_hex($urandom(), 8);
                repeat ($urandom_range(0, n - 1)) put_hex($urandom(), 2);
                if ($urandom_range(0, 1) == 1)
                    put_hex($urandom(), 1);
                line_buf.push_back(pick_non_hex());
            end
            default:
            begin
                repeat ($urandom_range(1, 12))
                    line_buf.push_back(CHAR_W'($urandom_range(0, 255)));
            end
        endcase
        repeat ($urandom_range(0, 3)) put_hex($urandom(), 2);
    endfunction

    function automatic void make_random_line();
        int          pick;
        int          nbytes;
        logic [31:0] addr;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            nbytes = ($urandom_range(0, 11) == 0) ? $urandom_range(9, 48)
                                                   : $urandom_range(0, 8);
            case ($urandom_range(0, 3))
                0: addr = {12'h000, 20'($urandom())};
                1: addr = $urandom();
                2: addr = 32'hFFFF_FFF8 + 32'($urandom_range(0, 7));
                default: addr = {12'($urandom_range(1, 4095)), 20'($urandom())};
            endcase
            put_text("S3");
            put_hex(nbytes + 5, 2);
            put_hex(addr, 8);
            repeat (nbytes) put_hex($urandom(), 2);
            put_hex($urandom(), 2);
        end
        else if (pick < 70)
        begin
            nbytes = $urandom_range(0, 6);
            put_text("S0");
            put_hex(nbytes + 3, 2);
            put_hex($urandom(), 4);
            repeat (nbytes) put_hex($urandom(), 2);
            put_hex($urandom(), 2);
        end
        else if (pick < 80)
        begin
            put_text("S7");
            put_hex($urandom_range(5, 7), 2);
            put_hex(($urandom_range(0, 3) == 0) ? 32'h0 : $urandom(), 8);
            put_hex($urandom(), 2);
        end
        else
        begin
            make_broken_line();
        end
        // Now and then the line is cut short or carries trailing text.
        if ($urandom_range(0, 9) == 0 && line_buf.size() > 2)
            repeat ($urandom_range(1, line_buf.size() - 2)) void'(line_buf.pop_back());
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 5)) line_buf.push_back(CHAR_W'($urandom_range(0, 255)));
        put_line_end();
    endfunction

    // Handshakes.

    task automatic send_char(input logic [CHAR_W-1:0] c);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            char_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_chan.valid   <= 1'b1;
        char_chan.char_in <= c;
        @(posedge clk);
        while (!char_chan.ready)
            @(posedge clk);
        decode_char(c);
        chars_sent++;
    endtask

    task automatic send_buffer();
        logic [CHAR_W-1:0] c;
        while (line_buf.size() > 0)
        begin
            c = line_buf.pop_front();
            send_char(c);
        end
    endtask

    // Holds the sender back until every expected word is in and the pipeline is empty.
    task automatic wait_for_quiet();
        char_chan.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read_check(input logic [PADDR_W-1:0] addr,
                                  input logic [PDATA_W-1:0] want, input string what);
        logic [PDATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        report_mismatch(what, want, got);
    endtask

    task automatic set_config(input logic mode, input logic [CORE_W-1:0] id);
        wait_for_quiet();
        apb_write({REG_BROADCAST_MODE, 2'b00}, {31'h0, mode});
        apb_write({REG_BROADCAST_CORE_ID, 2'b00}, {20'h0, id});
        cfg_mode    = mode;
        cfg_core_id = id;
        settings_applied++;
        apb_read_check({REG_BROADCAST_MODE, 2'b00}, {31'h0, mode}, "broadcast_mode readback");
        apb_read_check({REG_BROADCAST_CORE_ID, 2'b00}, {20'h0, id},
                       "broadcast_core_id readback");
    endtask

    // Tests.

    task automatic test_register_access();
        apb_read_check({REG_BROADCAST_MODE, 2'b00}, '0, "broadcast_mode after reset");
        apb_read_check({REG_BROADCAST_CORE_ID, 2'b00}, '0, "broadcast_core_id after reset");
        set_config(1'b1, 12'hFFF);
        set_config(1'b0, 12'h000);
    endtask

    task automatic test_local_records();
        put_text("S3070000100000FF5A\n");
        put_text("S0030ABC00\n");
        put_text("S3060001fffe7e55\r\n");
        put_text("S30640000000C3AA\n");
        put_text("S308FFFFFFFF112233\n");
        put_text("S005FFFF4E414D45\n");
        put_text("S30500000000FA\n");
        put_text("S70500001000EA\nS70500000000FA\rS705FFFFFFFF00\n");
        put_text("S3FF000000200102\n\n\r\n");
        send_buffer();
    endtask

    task automatic test_error_lines();
        line_buf.push_back(8'h00);
        line_buf.push_back(LF);
        line_buf.push_back(8'hFF);
        put_text("S3\n");
        put_text("QS30600000000AA\nS1\nSs\nS300\nS304\nS002\nS3G5\nS30g\n");
        put_text("S3050000Z000\nS0030A!C\nS3070000000012X4\nS0030A\nS70500\n");
        send_buffer();
    endtask

    task automatic test_broadcast_records();
        set_config(1'b1, 12'hFFF);
        put_text("S00312340F\nS306ABCDE123F000\nS70512345678\n");
        send_buffer();
        set_config(1'b1, 12'h000);
        put_text("S30612345678AB00\n");
        send_buffer();
        // The offset learnt from the broadcast S0 now applies to local addresses.
        set_config(1'b0, 12'h5A5);
        put_text("S3060000ABCD1100\n");
        send_buffer();
    endtask

    task automatic run_random_phase(input logic mode, input logic [CORE_W-1:0] id);
        int first;
        set_config(mode, id);
        first = chars_sent;
        while (chars_sent - first < PHASE_CHARS)
        begin
            if ($urandom_range(0, 9) == 0)
                sender_eager = !sender_eager;
            if ($urandom_range(0, 9) == 0)
                sink_eager = !sink_eager;
            if ($urandom_range(0, 29) == 0)
                wait_for_quiet();
            make_random_line();
            send_buffer();
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(1'b0, 12'($urandom_range(0, 4095)));
        run_random_phase(1'b1, 12'h000);
        run_random_phase(1'b1, 12'hFFF);
        run_random_phase(1'b0, 12'h000);
        run_random_phase(1'b1, 12'($urandom_range(0, 4095)));
    endtask

    // Result side: random back-pressure, one stall drawn per word.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sink_stall = 0;
            evt_chan.ready <= 1'b0;
        end
        else if (evt_chan.valid && evt_chan.ready)
        begin
            sink_stall = sink_eager ? 0 : $urandom_range(0, 17);
            evt_chan.ready <= (sink_stall == 0);
        end
        else if (sink_stall > 0)
        begin
            sink_stall = sink_stall - 1;
            if (sink_stall == 0)
                evt_chan.ready <= 1'b1;
        end
        else
        begin
            evt_chan.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && evt_chan.valid && evt_chan.ready)
        begin
            if (pending_events.size() == 0)
            begin
                if (fail_count < REPORT_CAP)
                    $display("%0t: word with nothing expected, got kind %0d addr 0x%0h data 0x%0h",
                             $time, evt_chan.event_kind, evt_chan.write_address,
                             evt_chan.write_data);
                fail_count++;
            end
            else
            begin
                want = pending_events.pop_front();
                report_mismatch("event_kind", 32'(want.event_kind), 32'(evt_chan.event_kind));
                report_mismatch("write_address", want.write_address, evt_chan.write_address);
                report_mismatch("write_data", 32'(want.write_data), 32'(evt_chan.write_data));
                kind_count[want.event_kind]++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_chan.valid && char_chan.ready) || (evt_chan.valid && evt_chan.ready)
                || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d words outstanding",
                         $time, QUIET_LIMIT, pending_events.size());
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        fail_count       = 0;
        chars_sent       = 0;
        settings_applied = 0;
        quiet_cycles     = 0;
        sender_eager     = 1'b0;
        sink_eager       = 1'b0;
        foreach (kind_count[k])
            kind_count[k] = 0;
        cfg_mode       = 1'b0;
        cfg_core_id    = '0;
        st_phase       = LOOK_FOR_S;
        st_kind        = REC_S0;
        st_digits      = '0;
        st_bytes       = '0;
        st_acc         = '0;
        st_nibble      = '0;
        st_core_offset = '0;

        rst_n             <= 1'b0;
        char_chan.valid   <= 1'b0;
        char_chan.char_in <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_local_records();
        test_error_lines();
        test_broadcast_records();
        test_random_traffic();

        wait_for_quiet();
        $display("Sent %0d characters of record text under %0d register settings.",
                 chars_sent, settings_applied);
        $display("Checked %0d writes, %0d section starts, %0d start addresses, %0d errors.",
                 kind_count[EV_WRITE], kind_count[EV_SECTION], kind_count[EV_START],
                 kind_count[EV_NO_S] + kind_count[EV_BAD_TYPE] + kind_count[EV_BAD_CNT]);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/srec_pkg.sv
rtl/srec_char_if.sv
rtl/srec_evt_if.sv
rtl/srec_cfg_regs.sv
rtl/srec_parser.sv
rtl/srec_out_stage.sv
rtl/srec_record_loader.sv
tb/testbench.sv
